[sv/cvmb_pkg.sv]
package cvmb_pkg;

  // Build-time sizing of the cell stack and the ADC.
  localparam int MAX_CELLS      = 5;
  localparam int CELL_CODE_BITS = 14;

  // Fixed field widths.
  localparam int NUM_CELLS_W = 3;
  localparam int GAIN_W      = 9;
  localparam int OFFSET_W    = 8;
  localparam int TRIP_W      = 23;
  localparam int DELTA_W     = 20;
  localparam int LIMIT_W     = 16;
  localparam int CUR_W       = 16;
  localparam int MIN_OUT_W   = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 23;

  // Derived datapath widths.
  localparam int PROD_W  = GAIN_W + CELL_CODE_BITS;
  localparam int VOLT_W  = PROD_W + 2;
  localparam int CMP_W   = ((VOLT_W > MIN_OUT_W) ? VOLT_W : MIN_OUT_W) + 1;
  localparam int THR_W   = ((VOLT_W > DELTA_W + 1) ? VOLT_W : DELTA_W + 1) + 1;
  localparam int CURP_W  = CUR_W + 10;
  localparam int LIMP_W  = LIMIT_W + 7;

  // Stream payload sizes, padded to whole bytes.
  localparam int IN_W        = MAX_CELLS * CELL_CODE_BITS + CUR_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = MAX_CELLS + 3 + MIN_OUT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Scaling constants: 8.44 mA per current code, offset given in mV.
  localparam int CUR_NUM_PER_CODE = 844;
  localparam int CUR_DEN          = 100;
  localparam int UV_PER_MV        = 1000;
  localparam int MIN_OUT_MAX      = 8388607;
  localparam int MIN_OUT_MIN      = -8388608;

  // Register indexes of the configuration port.
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_CELLS   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OV_TRIP     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UV_TRIP     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DELTA       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_CUR_LIMIT   = 3'd6;

  typedef struct packed {
    logic [NUM_CELLS_W-1:0]     num_cells;
    logic [GAIN_W-1:0]          gain_uv_per_lsb;
    logic signed [OFFSET_W-1:0] offset_mv;
    logic [TRIP_W-1:0]          ov_trip_uv;
    logic [TRIP_W-1:0]          uv_trip_uv;
    logic [DELTA_W-1:0]         balance_delta_uv;
    logic [LIMIT_W-1:0]         balance_current_limit_ma;
  } cfg_t;

  typedef struct packed {
    logic signed [CUR_W-1:0]                         current_code;
    logic [MAX_CELLS-1:0][CELL_CODE_BITS-1:0]        cell_code;
  } snap_t;

  // After stage 1: raw gain products and current magnitude.
  typedef struct packed {
    logic [MAX_CELLS-1:0][PROD_W-1:0] prod;
    logic [CUR_W-1:0]                 cur_abs;
  } s1_t;

  // After stage 2: cell voltages and the two sides of the current check.
  typedef struct packed {
    logic [MAX_CELLS-1:0][VOLT_W-1:0] volt;
    logic [CURP_W-1:0]                cur_prod;
    logic [LIMP_W-1:0]                lim_prod;
  } s2_t;

  // After stage 3: minimum, flags and the cells in use.
  typedef struct packed {
    logic [MAX_CELLS-1:0][VOLT_W-1:0] volt;
    logic [VOLT_W-1:0]                min_uv;
    logic [MAX_CELLS-1:0]             active;
    logic                             undervoltage;
    logic                             overvoltage;
    logic                             blocked;
  } s3_t;

  typedef struct packed {
    logic [MIN_OUT_W-1:0] min_cell_uv;
    logic                 balancing_blocked;
    logic                 overvoltage;
    logic                 undervoltage;
    logic [MAX_CELLS-1:0] balance_mask;
  } res_t;

endpackage

[sv/cvmb_conv.sv]
module cvmb_conv (
  input  logic           clk,
  input  logic           rst_n,
  input  cvmb_pkg::cfg_t cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  cvmb_pkg::snap_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cvmb_pkg::s2_t  dn_data
);
  import cvmb_pkg::*;

  logic              s1_vld_r;
  s1_t               s1_r;
  s1_t               s1_nxt;
  logic              s2_vld_r;
  s2_t               s2_r;
  s2_t               s2_nxt;
  logic              s1_ready;
  logic              s2_ready;
  logic signed [VOLT_W-1:0] off_uv;

  assign s2_ready = !s2_vld_r || dn_ready;
  assign s1_ready = !s1_vld_r || s2_ready;
  assign up_ready = s1_ready;

  // Stage 1: gain products and the magnitude of the current code.
  always_comb begin
    for (int i = 0; i < MAX_CELLS; i++) begin
      s1_nxt.prod[i] = PROD_W'(cfg.gain_uv_per_lsb) * PROD_W'(up_data.cell_code[i]);
    end
    if (up_data.current_code[CUR_W-1]) begin
      s1_nxt.cur_abs = CUR_W'(~up_data.current_code + CUR_W'(1));
    end else begin
      s1_nxt.cur_abs = CUR_W'(up_data.current_code);
    end
  end

  // Stage 2: add the offset and scale the current check.
  always_comb begin
    off_uv = VOLT_W'(cfg.offset_mv) * $signed(VOLT_W'(UV_PER_MV));
    for (int i = 0; i < MAX_CELLS; i++) begin
      s2_nxt.volt[i] = VOLT_W'($signed({2'b00, s1_r.prod[i]}) + off_uv);
    end
    s2_nxt.cur_prod = CURP_W'(s1_r.cur_abs) * CURP_W'(CUR_NUM_PER_CODE);
    s2_nxt.lim_prod = LIMP_W'(cfg.balance_current_limit_ma) * LIMP_W'(CUR_DEN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_vld_r <= up_valid;
      end
      if (s2_ready) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_r <= s1_nxt;
    end
    if (s2_ready && s1_vld_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign dn_valid = s2_vld_r;
  assign dn_data  = s2_r;

endmodule

[sv/cvmb_eval.sv]
module cvmb_eval (
  input  logic           clk,
  input  logic           rst_n,
  input  cvmb_pkg::cfg_t cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  cvmb_pkg::s2_t  up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cvmb_pkg::s3_t  dn_data
);
  import cvmb_pkg::*;

  logic                    s3_vld_r;
  s3_t                     s3_r;
  s3_t                     s3_nxt;
  logic                    found;
  logic signed [CMP_W-1:0] v_ext;
  logic signed [CMP_W-1:0] uv_ext;
  logic signed [CMP_W-1:0] ov_ext;

  assign up_ready = !s3_vld_r || dn_ready;

  // Flags and running minimum over the cells in use.
  always_comb begin
    found  = 1'b0;
    v_ext  = '0;
    uv_ext = $signed(CMP_W'(cfg.uv_trip_uv));
    ov_ext = $signed(CMP_W'(cfg.ov_trip_uv));
    s3_nxt.volt         = up_data.volt;
    s3_nxt.min_uv       = '0;
    s3_nxt.undervoltage = 1'b0;
    s3_nxt.overvoltage  = 1'b0;
    for (int i = 0; i < MAX_CELLS; i++) begin
      s3_nxt.active[i] = (cfg.num_cells > NUM_CELLS_W'(i));
      v_ext = CMP_W'($signed(up_data.volt[i]));
      if (s3_nxt.active[i]) begin
        if (v_ext <= uv_ext) begin
          s3_nxt.undervoltage = 1'b1;
        end
        if (v_ext >= ov_ext) begin
          s3_nxt.overvoltage = 1'b1;
        end
        if (!found || ($signed(up_data.volt[i]) < $signed(s3_nxt.min_uv))) begin
          s3_nxt.min_uv = up_data.volt[i];
        end
        found = 1'b1;
      end
    end
    s3_nxt.blocked = up_data.cur_prod > CURP_W'(up_data.lim_prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (up_ready) begin
      s3_vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      s3_r <= s3_nxt;
    end
  end

  assign dn_valid = s3_vld_r;
  assign dn_data  = s3_r;

endmodule

[sv/cvmb_mask.sv]
module cvmb_mask (
  input  logic           clk,
  input  logic           rst_n,
  input  cvmb_pkg::cfg_t cfg,
  input  logic           up_valid,
  output logic           up_ready,
  input  cvmb_pkg::s3_t  up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cvmb_pkg::res_t dn_data
);
  import cvmb_pkg::*;

  logic                    res_vld_r;
  res_t                    res_r;
  res_t                    res_nxt;
  logic signed [THR_W-1:0] thr;
  logic signed [CMP_W-1:0] min_ext;

  assign up_ready = !res_vld_r || dn_ready;

  // Balance threshold, mask and the saturated minimum.
  always_comb begin
    thr     = THR_W'($signed(up_data.min_uv)) + $signed(THR_W'(cfg.balance_delta_uv));
    min_ext = CMP_W'($signed(up_data.min_uv));
    for (int i = 0; i < MAX_CELLS; i++) begin
      res_nxt.balance_mask[i] = up_data.active[i] && !up_data.blocked &&
                                (THR_W'($signed(up_data.volt[i])) > thr);
    end
    res_nxt.undervoltage      = up_data.undervoltage;
    res_nxt.overvoltage       = up_data.overvoltage;
    res_nxt.balancing_blocked = up_data.blocked;
    if (min_ext > $signed(CMP_W'(MIN_OUT_MAX))) begin
      res_nxt.min_cell_uv = MIN_OUT_W'(MIN_OUT_MAX);
    end else if (min_ext < $signed(CMP_W'(MIN_OUT_MIN))) begin
      res_nxt.min_cell_uv = MIN_OUT_W'(MIN_OUT_MIN);
    end else begin
      res_nxt.min_cell_uv = MIN_OUT_W'(min_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (up_ready) begin
      res_vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r <= res_nxt;
    end
  end

  assign dn_valid = res_vld_r;
  assign dn_data  = res_r;

endmodule

[sv/cell_voltage_monitor_balancer.sv]
// Channel   Direction  Transaction                    Fields (tdata, lowest bit first)
// in_*      slave      one snapshot of the cell stack cell1..cell5_code (14 b each),
//                                                     current_code (16 b, signed), zero pad
// out_*     master     one monitor result per snapshot balance_mask (5 b), undervoltage,
//                                                     overvoltage, balancing_blocked,
//                                                     min_cell_uv (24 b, signed)
// cfg_*     write-only register writes                cfg_addr selects, cfg_wdata holds value
//
// Every snapshot yields exactly one result, presented on out_* once it has passed the
// four register stages in order: gain multiply, offset and current scaling, minimum and
// trip flags, then the balance mask into the output register. While out_tready stays
// high a new snapshot can be taken on every cycle, so the sustained rate is one
// transaction per cycle.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the default configuration.
// Each stage holds its transaction while the stage after it is full and stalled, so a stall
// on out_tready back-pressures in_tready only once every stage holds a transaction.
module cell_voltage_monitor_balancer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [cvmb_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [cvmb_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // Snapshot input stream.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // cell1_code, cell2_code, cell3_code, cell4_code, cell5_code, current_code, padding
  input  logic [cvmb_pkg::IN_TDATA_W-1:0]       in_tdata,
  // Result output stream.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // balance_mask, undervoltage, overvoltage, balancing_blocked, min_cell_uv
  output logic [cvmb_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import cvmb_pkg::*;

  cfg_t  cfg_r;
  snap_t snap;
  logic  conv_valid;
  logic  conv_ready;
  s2_t   conv_data;
  logic  eval_valid;
  logic  eval_ready;
  s3_t   eval_data;
  res_t  res;

  // Configuration registers. Writes to an index beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_cells                <= NUM_CELLS_W'(5);
      cfg_r.gain_uv_per_lsb          <= GAIN_W'(380);
      cfg_r.offset_mv                <= '0;
      cfg_r.ov_trip_uv               <= TRIP_W'(4200000);
      cfg_r.uv_trip_uv               <= TRIP_W'(2800000);
      cfg_r.balance_delta_uv         <= DELTA_W'(20000);
      cfg_r.balance_current_limit_ma <= LIMIT_W'(50);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NUM_CELLS: cfg_r.num_cells                <= cfg_wdata[NUM_CELLS_W-1:0];
        REG_GAIN:      cfg_r.gain_uv_per_lsb          <= cfg_wdata[GAIN_W-1:0];
        REG_OFFSET:    cfg_r.offset_mv                <= $signed(cfg_wdata[OFFSET_W-1:0]);
        REG_OV_TRIP:   cfg_r.ov_trip_uv               <= cfg_wdata[TRIP_W-1:0];
        REG_UV_TRIP:   cfg_r.uv_trip_uv               <= cfg_wdata[TRIP_W-1:0];
        REG_DELTA:     cfg_r.balance_delta_uv         <= cfg_wdata[DELTA_W-1:0];
        REG_CUR_LIMIT: cfg_r.balance_current_limit_ma <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The cell codes sit in tdata in the same order as the packed array, cell 1 lowest.
  assign snap.cell_code    = in_tdata[MAX_CELLS*CELL_CODE_BITS-1:0];
  assign snap.current_code = $signed(in_tdata[MAX_CELLS*CELL_CODE_BITS +: CUR_W]);

  // Stages 1 and 2: cell codes to microvolts, current to the scaled magnitude.
  cvmb_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (snap),
    .dn_valid (conv_valid),
    .dn_ready (conv_ready),
    .dn_data  (conv_data)
  );

  // Stage 3: active cells, trip flags, minimum and the current check.
  cvmb_eval u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (conv_valid),
    .up_ready (conv_ready),
    .up_data  (conv_data),
    .dn_valid (eval_valid),
    .dn_ready (eval_ready),
    .dn_data  (eval_data)
  );

  // Stage 4: balance mask against minimum plus delta, into the output register.
  cvmb_mask u_mask (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (eval_valid),
    .up_ready (eval_ready),
    .up_data  (eval_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res)
  );

  assign out_tdata = OUT_TDATA_W'(res);

`ifndef SYNTHESIS
  // A blocked result never carries a balance request.
  a_blocked_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.balancing_blocked |-> res.balance_mask == '0)
    else $error("balance mask set while balancing is blocked");

  // The lowest cell can never exceed itself plus delta, so not every cell is balanced.
  a_mask_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res.balance_mask != {MAX_CELLS{1'b1}})
    else $error("balance mask includes the minimum cell");

  // Input back-pressure only arises from a full pipeline behind a stalled output.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && conv_valid && eval_valid)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

[tb/tb_cell_voltage_monitor_balancer.sv]
module tb_cell_voltage_monitor_balancer;
  timeunit 1ns;
  timeprecision 1ps;

  import cvmb_pkg::*;

  // Clock period is 4 ns; reset is held low from the start of the run.
  localparam int CLK_HALF    = 2;
  localparam int RESET_EDGES = 8;

  // Edges waited after the last result, to catch any stray transaction.
  localparam int SETTLE_EDGES = 8;

  // Watchdog limit, far beyond the length of the slowest correct run.
  localparam int CYCLE_LIMIT = 200000;

  localparam int CODE_MAX = (1 << CELL_CODE_BITS) - 1;

  // Register index 7 is not decoded; writes to it must change nothing.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

  // Current scaling is 8.44 mA per code, compared exactly as code * 844 against
  // limit * 100. Offset is held in millivolts and applied in microvolts.
  localparam longint CUR_SCALE_NUM = 844;
  localparam longint CUR_SCALE_DEN = 100;
  localparam longint UV_PER_MILLIVOLT = 1000;
  localparam longint MIN_REPORT_HI = 8388607;
  localparam longint MIN_REPORT_LO = -8388608;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // cell1_code .. cell5_code (14 b each), current_code (16 b, signed), zero pad
  logic [IN_TDATA_W-1:0] in_tdata  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // balance_mask (5 b), undervoltage, overvoltage, balancing_blocked, min_cell_uv (24 b)
  logic [OUT_TDATA_W-1:0] out_tdata;

  // The testbench's own copy of the register file, updated whenever the
  // configuration is rewritten. It only changes while the block is idle.
  cfg_t shadow_cfg;

  // Monitor results still owed by the block, oldest first.
  res_t pending_results[$];

  int mismatch_count = 0;
  int cycle_count    = 0;

  // Percentage of cycles in which the snapshot source and the result sink hold off.
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  cell_voltage_monitor_balancer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Watchdog: a run that is still going long after it should have ended is a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The result sink withholds tready at random; the percentage is set per phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Works out the one result that a snapshot produces under the current register
  // settings. Voltages are kept exact in 64 bits; only the reported minimum is
  // clamped to the 24-bit signed output range.
  function automatic res_t predict_monitor_result(snap_t s);
    longint volt [MAX_CELLS];
    longint cur_mag;
    longint lowest;
    longint thr;
    int     n_active;
    int     i;
    res_t   r;
    r = '0;
    n_active = (shadow_cfg.num_cells > MAX_CELLS) ? MAX_CELLS : int'(shadow_cfg.num_cells);

    cur_mag = longint'($signed(s.current_code));
    if (cur_mag < 0) cur_mag = -cur_mag;
    r.balancing_blocked = (cur_mag * CUR_SCALE_NUM >
                           longint'(shadow_cfg.balance_current_limit_ma) * CUR_SCALE_DEN);

    // With no active cell the minimum is reported as zero and neither trip flag is raised.
    lowest = 0;
    for (i = 0; i < n_active; i++) begin
      volt[i] = longint'(shadow_cfg.gain_uv_per_lsb) * longint'(s.cell_code[i]) +
                longint'($signed(shadow_cfg.offset_mv)) * UV_PER_MILLIVOLT;
      if (i == 0 || volt[i] < lowest) lowest = volt[i];
      if (volt[i] <= longint'(shadow_cfg.uv_trip_uv)) r.undervoltage = 1'b1;
      if (volt[i] >= longint'(shadow_cfg.ov_trip_uv)) r.overvoltage = 1'b1;
    end

    // A blocked balance leaves the mask clear but the minimum is still reported.
    if (!r.balancing_blocked) begin
      thr = lowest + longint'(shadow_cfg.balance_delta_uv);
      for (i = 0; i < n_active; i++) begin
        if (volt[i] > thr) r.balance_mask[i] = 1'b1;
      end
    end

    if (lowest > MIN_REPORT_HI) lowest = MIN_REPORT_HI;
    if (lowest < MIN_REPORT_LO) lowest = MIN_REPORT_LO;
    r.min_cell_uv = lowest[MIN_OUT_W-1:0];
    return r;
  endfunction

  // Scoreboard. Every accepted snapshot queues its expected result at the same edge,
  // before the output side is looked at, so ordering within a time step never matters.
  always @(posedge clk) begin
    snap_t taken;
    res_t  want;
    res_t  got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        taken = in_tdata[$bits(snap_t)-1:0];
        pending_results.push_back(predict_monitor_result(taken));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(res_t)-1:0];
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing outstanding: %h", out_tdata);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.balance_mask !== want.balance_mask) begin
            $error("balance_mask: expected %b, got %b", want.balance_mask, got.balance_mask);
            mismatch_count++;
          end
          if (got.undervoltage !== want.undervoltage) begin
            $error("undervoltage: expected %b, got %b", want.undervoltage, got.undervoltage);
            mismatch_count++;
          end
          if (got.overvoltage !== want.overvoltage) begin
            $error("overvoltage: expected %b, got %b", want.overvoltage, got.overvoltage);
            mismatch_count++;
          end
          if (got.balancing_blocked !== want.balancing_blocked) begin
            $error("balancing_blocked: expected %b, got %b",
                   want.balancing_blocked, got.balancing_blocked);
            mismatch_count++;
          end
          if (got.min_cell_uv !== want.min_cell_uv) begin
            $error("min_cell_uv: expected %0d, got %0d",
                   $signed(want.min_cell_uv), $signed(got.min_cell_uv));
            mismatch_count++;
          end
        end
      end
    end
  end

  function automatic cfg_t make_cfg(int n, int gain, int off, int ov, int uv,
                                    int delta, int limit);
    cfg_t c;
    c.num_cells                = NUM_CELLS_W'(n);
    c.gain_uv_per_lsb          = GAIN_W'(gain);
    c.offset_mv                = OFFSET_W'(off);
    c.ov_trip_uv               = TRIP_W'(ov);
    c.uv_trip_uv               = TRIP_W'(uv);
    c.balance_delta_uv         = DELTA_W'(delta);
    c.balance_current_limit_ma = LIMIT_W'(limit);
    return c;
  endfunction

  function automatic snap_t snap_of(int c1, int c2, int c3, int c4, int c5, int cur);
    snap_t s;
    s.cell_code[0] = c1[CELL_CODE_BITS-1:0];
    s.cell_code[1] = c2[CELL_CODE_BITS-1:0];
    s.cell_code[2] = c3[CELL_CODE_BITS-1:0];
    s.cell_code[3] = c4[CELL_CODE_BITS-1:0];
    s.cell_code[4] = c5[CELL_CODE_BITS-1:0];
    s.current_code = cur[CUR_W-1:0];
    return s;
  endfunction

  // One register write per edge; the enable is left high so that back-to-back
  // writes never lower and raise it within the same step.
  task automatic put_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Rewrites every register, plus the undecoded index, and then updates the shadow copy.
  // Only called while nothing is in flight.
  task automatic apply_config(cfg_t c);
    put_reg(REG_NUM_CELLS, CFG_DATA_W'(c.num_cells));
    put_reg(REG_GAIN,      CFG_DATA_W'(c.gain_uv_per_lsb));
    put_reg(REG_OFFSET,    CFG_DATA_W'(c.offset_mv));
    put_reg(REG_OV_TRIP,   CFG_DATA_W'(c.ov_trip_uv));
    put_reg(REG_UV_TRIP,   CFG_DATA_W'(c.uv_trip_uv));
    put_reg(REG_DELTA,     CFG_DATA_W'(c.balance_delta_uv));
    put_reg(REG_CUR_LIMIT, CFG_DATA_W'(c.balance_current_limit_ma));
    put_reg(REG_SPARE,     CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    shadow_cfg = c;
  endtask

  // Offers one snapshot and returns once the block has taken it. Source idling
  // lowers tvalid for whole cycles; tvalid stays high between back-to-back transactions.
  task automatic send_snapshot(snap_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(s);
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering snapshots and waits until every owed result has been checked,
  // then lets the pipeline settle so that the block is truly idle.
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_EDGES) @(posedge clk);
  endtask

  // Snapshots mostly hold cells clustered round a common level, so that the minimum,
  // the balance threshold and the trip points all come into play; a few are pure
  // noise or rail values. Current sits mostly near or below the balance limit.
  function automatic snap_t random_snapshot();
    snap_t s;
    int    kind;
    int    base;
    int    spread;
    int    lim_codes;
    int    cur;
    int    i;
    kind   = $urandom_range(99);
    base   = $urandom_range(4000, 12500);
    spread = ($urandom_range(3) == 0) ? 400 : 60;
    for (i = 0; i < MAX_CELLS; i++) begin
      if (kind < 10) s.cell_code[i] = CELL_CODE_BITS'($urandom);
      else if (kind < 15) s.cell_code[i] = CELL_CODE_BITS'($urandom_range(1) ? CODE_MAX : 0);
      else s.cell_code[i] = CELL_CODE_BITS'(base + $urandom_range(spread));
    end

    lim_codes = int'(shadow_cfg.balance_current_limit_ma) * 100 / 844;
    kind = $urandom_range(99);
    if (kind < 40) cur = $urandom_range(lim_codes);
    else if (kind < 65) cur = lim_codes + $urandom_range(4) - 2;
    else if (kind < 80) cur = $urandom_range(300);
    else cur = $urandom_range(65535);
    if ($urandom_range(1)) cur = -cur;
    s.current_code = cur[CUR_W-1:0];
    return s;
  endfunction

  // Ordinary settings keep to the calibrated ranges but for the offset, which spans every
  // bit; wide ones sweep every register bit, including cell counts of zero and above the stack size.
  function automatic cfg_t random_config(bit wide);
    cfg_t c;
    c.num_cells       = NUM_CELLS_W'(wide ? $urandom_range(7) : $urandom_range(5, 3));
    c.gain_uv_per_lsb = GAIN_W'(wide ? $urandom_range(511) : $urandom_range(396, 365));
    c.offset_mv       = OFFSET_W'($urandom);
    c.ov_trip_uv      = TRIP_W'(wide ? $urandom : $urandom_range(4600000, 3600000));
    c.uv_trip_uv      = TRIP_W'(wide ? $urandom : $urandom_range(3400000, 2400000));
    c.balance_delta_uv = DELTA_W'(wide ? $urandom : $urandom_range(60000));
    c.balance_current_limit_ma = LIMIT_W'(wide ? $urandom : $urandom_range(2500));
    return c;
  endfunction

  // Power-on settings: empty and rail codes, the exact balance threshold, both
  // trip points at the default calibration, and the current limit either side.
  task automatic test_reset_defaults();
    send_snapshot(snap_of(0, 0, 0, 0, 0, 0));
    send_snapshot(snap_of(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, -32768));
    send_snapshot(snap_of(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, 32767));
    send_snapshot(snap_of(8000, 8100, 8000, 8052, 8053, 5));
    send_snapshot(snap_of(8000, 8100, 8000, 8052, 8053, -6));
    send_snapshot(snap_of(7368, 7369, 11052, 11053, 9000, -5));
    drain_pipeline();
  endtask

  // Thresholds that fall exactly on a code: a cell at a trip point raises its flag,
  // a cell exactly at min plus delta is not balanced, and the current sits either side of the limit.
  task automatic test_trip_edges();
    apply_config(make_cfg(5, 400, 0, 4000000, 2800000, 20000, 100));
    send_snapshot(snap_of(7000, 8000, 8000, 8000, 8000, 0));
    send_snapshot(snap_of(7001, 9999, 8000, 8000, 8000, 0));
    send_snapshot(snap_of(8000, 10000, 8000, 8000, 8000, 11));
    send_snapshot(snap_of(8000, 8050, 8051, 8000, 8049, -11));
    send_snapshot(snap_of(8000, 8050, 8051, 8000, 8049, 12));
    drain_pipeline();
  endtask

  // Cell count zero, a partial stack with rail codes in the unused slots, and counts
  // beyond the stack that must behave as a full stack.
  task automatic test_cell_count();
    apply_config(make_cfg(0, 380, 0, 4200000, 2800000, 20000, 50));
    send_snapshot(snap_of(0, CODE_MAX, 0, CODE_MAX, 0, 0));
    send_snapshot(snap_of(0, CODE_MAX, 0, CODE_MAX, 0, 32767));
    drain_pipeline();
    apply_config(make_cfg(3, 380, 0, 4200000, 2800000, 20000, 50));
    send_snapshot(snap_of(8000, 8100, 8200, 0, CODE_MAX, 0));
    send_snapshot(snap_of(8000, 8100, 8200, CODE_MAX, 0, 0));
    drain_pipeline();
    apply_config(make_cfg(6, 380, 0, 4200000, 2800000, 20000, 50));
    send_snapshot(snap_of(8000, 8100, 8000, 8000, 8200, 0));
    drain_pipeline();
    apply_config(make_cfg(7, 380, 0, 4200000, 2800000, 20000, 50));
    send_snapshot(snap_of(8200, 8000, 8000, 8000, 7000, 0));
    drain_pipeline();
  endtask

  // Register extremes: a minimum that overflows the reported range, the widest
  // negative offset with zero gain, trips at both ends and the widest delta and limit.
  task automatic test_extremes();
    apply_config(make_cfg(5, 511, 127, 8388607, 8388607, 0, 65535));
    send_snapshot(snap_of(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, -32768));
    send_snapshot(snap_of(CODE_MAX, CODE_MAX, CODE_MAX, CODE_MAX, 16000, 7764));
    drain_pipeline();
    apply_config(make_cfg(5, 0, -128, 0, 0, 1048575, 0));
    send_snapshot(snap_of(CODE_MAX, 0, CODE_MAX, 0, CODE_MAX, 0));
    send_snapshot(snap_of(CODE_MAX, 0, CODE_MAX, 0, CODE_MAX, 1));
    drain_pipeline();
  endtask

  // Three settings per call, the last one wide; halfway through each setting the
  // source waits for every outstanding result before carrying on.
  task automatic test_random_snapshots(int n_items);
    int k;
    int j;
    for (k = 0; k < 3; k++) begin
      apply_config(random_config(k == 2));
      for (j = 0; j < n_items / 3; j++) begin
        send_snapshot(random_snapshot());
        if (j == n_items / 6) drain_pipeline();
      end
      drain_pipeline();
    end
  endtask

  initial begin
    shadow_cfg = make_cfg(5, 380, 0, 4200000, 2800000, 20000, 50);
    repeat (RESET_EDGES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First phase: the source idles in 29 percent of cycles, the sink in 48 percent.
    src_idle_pct = 29;
    snk_idle_pct = 48;
    test_reset_defaults();
    test_trip_edges();
    test_cell_count();
    test_extremes();
    test_random_snapshots(150);

    // Second phase: the idling is swapped round.
    src_idle_pct = 48;
    snk_idle_pct = 29;
    test_random_snapshots(150);

    // Last phase: full rate on both sides.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_snapshots(150);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[cell_voltage_monitor_balancer.f]
sv/cvmb_pkg.sv
sv/cvmb_conv.sv
sv/cvmb_eval.sv
sv/cvmb_mask.sv
sv/cell_voltage_monitor_balancer.sv
tb/tb_cell_voltage_monitor_balancer.sv
